// ===== rtl/lcb_pkg.sv =====
// Shared types and constants for the LRU cache byte budget unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

	localparam int MAX_PAGES_DEF = 1024;

	localparam int PAGE_W  = 10;
	localparam int BYTES_W = 24;
	localparam int TOTAL_W = 40;
	localparam int PCNT_W  = 11;
	localparam int EVC_W   = 10;
	localparam int CNT_W   = 32;

	typedef enum logic {
		MODE_ACCESS = 1'b0,
		MODE_CLEAR  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STAT_HIT     = 2'd0,
		STAT_MISS    = 2'd1,
		STAT_RANGE   = 2'd2,
		STAT_CLEARED = 2'd3
	} status_t;

	typedef enum logic {
		CFG_PAGE_COUNT  = 1'b0,
		CFG_BYTE_BUDGET = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_LOOK,
		ST_HIT_O,
		ST_HIT_H,
		ST_HIT_P,
		ST_MISS_H,
		ST_EV_CHK,
		ST_EV_RD,
		ST_DONE
	} state_t;

	// per-field write enables of the entry memory
	typedef struct packed {
		logic res;
		logic size;
		logic newer;
		logic older;
	} wmask_t;

	typedef struct packed {
		mode_t               mode;
		logic [PAGE_W-1:0]   page;
		logic [BYTES_W-1:0]  entry_bytes;
	} in_t;

	typedef struct packed {
		status_t             status;
		logic [EVC_W-1:0]    evicted_count;
		logic [TOTAL_W-1:0]  total_bytes;
		logic [PCNT_W-1:0]   cached_pages;
		logic [CNT_W-1:0]    hit_count;
		logic [CNT_W-1:0]    miss_count;
		logic [CNT_W-1:0]    eviction_count;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/lru_cache_byte_budget_unit.sv =====
// Top level of the LRU cache byte budget unit: configuration registers,
// sequencer and entry memory. Depends on lcb_pkg, lcb_ctrl, lcb_entry_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | input     | in_valid/in_stall  | in_data (in_t)
//  out     | output    | out_valid/out_stall| out_data (out_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Items are worked one at a time through the single write port of the entry
// memory: an out-of-range item and a hit on the newest page write nothing,
// another hit relinks the list, a miss inserts and evicts while over budget,
// a clear sweeps every page. After reset a sweep clears the resident flags;
// in_stall stays high meanwhile. Configuration writes are taken every cycle.
// A stalled result waits in the output register; the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module lru_cache_byte_budget_unit
	import lcb_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	localparam int PW = $clog2(MAX_PAGES)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_t                in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_t                    out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire cfg_reg_t           cfg_index,
	input  wire logic [TOTAL_W-1:0] cfg_data
);

	logic [PCNT_W-1:0]  page_count_q;
	logic [TOTAL_W-1:0] byte_budget_q;
	wmask_t             wmask;
	logic [PW-1:0]      waddr, wnewer, wolder, raddr, rd_newer, rd_older;
	logic               wres, rd_en, rd_res;
	logic [BYTES_W-1:0] wsize, rd_size;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q  <= '0;
			byte_budget_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAGE_COUNT:  page_count_q  <= cfg_data[PCNT_W-1:0];
				CFG_BYTE_BUDGET: byte_budget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lcb_ctrl #(.MAX_PAGES(MAX_PAGES)) u_ctrl (
		.clk, .arst_n,
		.page_count(page_count_q), .byte_budget(byte_budget_q),
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.wmask, .waddr, .wres, .wsize, .wnewer, .wolder,
		.rd_en, .raddr, .rd_res, .rd_size, .rd_newer, .rd_older
	);

	lcb_entry_ram #(.MAX_PAGES(MAX_PAGES)) u_ram (
		.clk,
		.wmask, .waddr, .wres, .wsize, .wnewer, .wolder,
		.rd_en, .raddr, .rd_res, .rd_size, .rd_newer, .rd_older
	);

endmodule

`default_nettype wire

// ===== rtl/lcb_entry_ram.sv =====
// Entry memory: resident flag, size and both recency links per page.
// Depends on lcb_pkg. One write port with field enables, one registered read.
`timescale 1ns / 1ps
`default_nettype none

module lcb_entry_ram
	import lcb_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	localparam int PW = $clog2(MAX_PAGES)
) (
	input  wire logic               clk,
	input  wire wmask_t             wmask,
	input  wire logic [PW-1:0]      waddr,
	input  wire logic               wres,
	input  wire logic [BYTES_W-1:0] wsize,
	input  wire logic [PW-1:0]      wnewer,
	input  wire logic [PW-1:0]      wolder,
	input  wire logic               rd_en,
	input  wire logic [PW-1:0]      raddr,
	output logic                    rd_res,
	output logic [BYTES_W-1:0]      rd_size,
	output logic [PW-1:0]           rd_newer,
	output logic [PW-1:0]           rd_older
);

	logic               mem_res   [MAX_PAGES];
	logic [BYTES_W-1:0] mem_size  [MAX_PAGES];
	logic [PW-1:0]      mem_newer [MAX_PAGES];
	logic [PW-1:0]      mem_older [MAX_PAGES];

	// masked write
	always_ff @(posedge clk) begin
		if (wmask.res)   mem_res[waddr]   <= wres;
		if (wmask.size)  mem_size[waddr]  <= wsize;
		if (wmask.newer) mem_newer[waddr] <= wnewer;
		if (wmask.older) mem_older[waddr] <= wolder;
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_res   <= mem_res[raddr];
			rd_size  <= mem_size[raddr];
			rd_newer <= mem_newer[raddr];
			rd_older <= mem_older[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcb_ctrl.sv =====
// Sequencer: lookup, list relinking, insertion, eviction walk, clear sweep
// and result register. Depends on lcb_pkg; drives lcb_entry_ram.
`timescale 1ns / 1ps
`default_nettype none

module lcb_ctrl
	import lcb_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	localparam int PW = $clog2(MAX_PAGES),
	localparam int CW = $clog2(MAX_PAGES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [PCNT_W-1:0]  page_count,
	input  wire logic [TOTAL_W-1:0] byte_budget,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_t                in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_t                    out_data,
	output wmask_t                  wmask,
	output logic [PW-1:0]           waddr,
	output logic                    wres,
	output logic [BYTES_W-1:0]      wsize,
	output logic [PW-1:0]           wnewer,
	output logic [PW-1:0]           wolder,
	output logic                    rd_en,
	output logic [PW-1:0]           raddr,
	input  wire logic               rd_res,
	input  wire logic [BYTES_W-1:0] rd_size,
	input  wire logic [PW-1:0]      rd_newer,
	input  wire logic [PW-1:0]      rd_older
);

	state_t              state_q, state_d;
	logic [PW-1:0]       sweep_q;
	logic                clr_q;
	logic [PW-1:0]       page_q, head_q, tail_q, oldhead_q, nlink_q, olink_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [CW-1:0]       total_q, evicted_q;
	logic [TOTAL_W-1:0]  btot_q;
	logic [CNT_W-1:0]    hits_q, miss_q, evc_q;
	status_t             status_q;
	logic                out_valid_q;
	out_t                out_q;
	logic                in_range;
	logic                evict_go;
	logic                out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign in_range = ({{(CNT_W-PAGE_W){1'b0}}, in_data.page} <
			{{(CNT_W-PCNT_W){1'b0}}, page_count}) &&
		(int'(in_data.page) < MAX_PAGES);
	assign evict_go = (byte_budget != '0) && (btot_q > byte_budget) &&
		(total_q > CW'(1));

	// next state and memory commands
	always_comb begin
		state_d = state_q;
		wmask   = '0;
		waddr   = page_q;
		wres    = 1'b0;
		wsize   = bytes_q;
		wnewer  = page_q;
		wolder  = head_q;
		rd_en   = 1'b0;
		raddr   = PW'(in_data.page);
		unique case (state_q)
			ST_SWEEP: begin
				wmask.res = 1'b1;
				waddr     = sweep_q;
				if (sweep_q == PW'(MAX_PAGES - 1)) state_d = clr_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.mode == MODE_CLEAR) state_d = ST_SWEEP;
					else if (!in_range) state_d = ST_DONE;
					else begin
						rd_en   = 1'b1;
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (rd_res) begin
					if (page_q == head_q) state_d = ST_DONE;
					else begin
						// older link of the newer neighbor skips this page
						wmask.older = 1'b1;
						waddr       = rd_newer;
						wolder      = rd_older;
						state_d     = ST_HIT_O;
					end
				end else begin
					wmask  = '{res: 1'b1, size: 1'b1, newer: 1'b1, older: 1'b1};
					wres   = 1'b1;
					state_d = (total_q != '0) ? ST_MISS_H : ST_EV_CHK;
				end
			end
			ST_HIT_O: begin
				if (page_q != tail_q) begin
					wmask.newer = 1'b1;
					waddr       = olink_q;
					wnewer      = nlink_q;
				end
				state_d = ST_HIT_H;
			end
			ST_HIT_H: begin
				wmask.newer = 1'b1;
				waddr       = head_q;
				state_d     = ST_HIT_P;
			end
			ST_HIT_P: begin
				wmask.newer = 1'b1;
				wmask.older = 1'b1;
				state_d     = ST_DONE;
			end
			ST_MISS_H: begin
				wmask.newer = 1'b1;
				waddr       = oldhead_q;
				state_d     = ST_EV_CHK;
			end
			ST_EV_CHK: begin
				if (evict_go) begin
					rd_en   = 1'b1;
					raddr   = tail_q;
					state_d = ST_EV_RD;
				end else state_d = ST_DONE;
			end
			ST_EV_RD: begin
				wmask.res = 1'b1;
				waddr     = tail_q;
				state_d   = ST_EV_CHK;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_SWEEP;
		else state_q <= state_d;
	end

	// list pointers, totals and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			clr_q     <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			total_q   <= '0;
			btot_q    <= '0;
			hits_q    <= '0;
			miss_q    <= '0;
			evc_q     <= '0;
			evicted_q <= '0;
			status_q  <= STAT_HIT;
		end else begin
			unique case (state_q)
				ST_SWEEP: sweep_q <= sweep_q + PW'(1);
				ST_IDLE: begin
					evicted_q <= '0;
					sweep_q   <= '0;
					if (in_valid) begin
						if (in_data.mode == MODE_CLEAR) begin
							clr_q    <= 1'b1;
							total_q  <= '0;
							btot_q   <= '0;
							status_q <= STAT_CLEARED;
						end else if (!in_range) status_q <= STAT_RANGE;
					end
				end
				ST_LOOK: begin
					if (rd_res) begin
						hits_q   <= hits_q + CNT_W'(1);
						status_q <= STAT_HIT;
					end else begin
						miss_q   <= miss_q + CNT_W'(1);
						status_q <= STAT_MISS;
						head_q   <= page_q;
						if (total_q == '0) tail_q <= page_q;
						total_q  <= total_q + CW'(1);
						btot_q   <= btot_q + TOTAL_W'(bytes_q);
					end
				end
				ST_HIT_O: if (page_q == tail_q) tail_q <= nlink_q;
				ST_HIT_P: head_q <= page_q;
				ST_EV_RD: begin
					tail_q    <= rd_newer;
					btot_q    <= btot_q - TOTAL_W'(rd_size);
					total_q   <= total_q - CW'(1);
					evc_q     <= evc_q + CNT_W'(1);
					evicted_q <= evicted_q + CW'(1);
				end
				ST_DONE: clr_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// item payload and link snapshot
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			page_q  <= PW'(in_data.page);
			bytes_q <= in_data.entry_bytes;
		end
		if (state_q == ST_LOOK) begin
			oldhead_q <= head_q;
			nlink_q   <= rd_newer;
			olink_q   <= rd_older;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.status         <= status_q;
			out_q.evicted_count  <= EVC_W'(evicted_q);
			out_q.total_bytes    <= btot_q;
			out_q.cached_pages   <= PCNT_W'(total_q);
			out_q.hit_count      <= hits_q;
			out_q.miss_count     <= miss_q;
			out_q.eviction_count <= evc_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcb_checker.sv =====
// Port-level checks for lru_cache_byte_budget_unit, attached by bind.
// Depends on lcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcb_checker
	import lcb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire out_t out_data
);

	// one item at a time: a transfer in closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_CLEARED |->
		out_data.cached_pages == '0 && out_data.total_bytes == '0 &&
		out_data.evicted_count == '0)
		else $error("clear left entries");

	a_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_HIT || out_data.status == STAT_RANGE) |->
		out_data.evicted_count == '0)
		else $error("eviction without insert");

endmodule

bind lru_cache_byte_budget_unit lcb_checker u_lcb_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

`default_nettype wire
